// File: hdl/rsn_pkg.sv
// Shared types, constants and helpers for the ray/sphere nearest-hit shader.
// Used by the square-root cells, the square-root chain, the divider and the top level.
// No dependencies.
package rsn_pkg;

	// Table and register geometry.
	localparam int MAX_SPHERES = 16;
	localparam int SLOT_W      = $clog2(MAX_SPHERES);
	localparam int COUNT_W     = $clog2(MAX_SPHERES + 1);
	localparam int CFG_IDX_W   = 8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z     = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPHERE_COUNT = 8'd3;

	// Input command codes.
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_TRACE = 1'b1;

	// Square-root chain geometry: one result bit per cell.
	localparam int RAD_W      = 64;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int REM_W      = ROOT_W + 3;
	localparam int SQRT_CELLS = ROOT_W;

	// Hit distance threshold, Q16.16.
	localparam logic signed [34:0] EPS_Q = 35'sd7;

	// Background and zero-normal colors.
	localparam logic [7:0] BG_RED   = 8'd51;
	localparam logic [7:0] BG_GREEN = 8'd77;
	localparam logic [7:0] BG_BLUE  = 8'd153;
	localparam logic [7:0] MID_GRAY = 8'd128;

	// What a square-root job belongs to.
	typedef enum logic {
		KIND_SPHERE,
		KIND_NORMAL
	} sq_kind_t;

	// Side data that travels with a square-root job.
	typedef struct packed {
		sq_kind_t         kind;
		logic             ok;
		logic [31:0]      b;
		logic [2:0][31:0] oc;
	} sq_tag_t;

	// One stage of the square-root chain.
	typedef struct packed {
		logic              valid;
		sq_tag_t           tag;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [RAD_W-1:0]  rad;
	} sq_stage_t;

	// Saturate a signed value to signed 32 bits.
	function automatic logic [31:0] sat32(input logic signed [39:0] v);
		logic [31:0] r;
		if (v > 40'sh00_7FFF_FFFF) begin
			r = 32'h7FFF_FFFF;
		end else if (v < 40'shFF_8000_0000) begin
			r = 32'h8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

// File: hdl/rsn_sqrt_cell.sv
// One cell of the integer square-root chain: settles one result bit per cell.
// Depends on rsn_pkg for the stage structure and widths.
module rsn_sqrt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  rsn_pkg::sq_stage_t stage_in,
	output rsn_pkg::sq_stage_t stage_out
);
	import rsn_pkg::*;

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic [REM_W-1:0] rem_sub;
	logic             fits;

	logic              valid_q;
	sq_tag_t           tag_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [RAD_W-1:0]  rad_q;

	// Bring down the next two radicand bits and try the next root bit.
	always_comb begin
		rem_sh  = {stage_in.rem[REM_W-3:0], stage_in.rad[RAD_W-1 -: 2]};
		trial   = {1'b0, stage_in.root, 2'b01};
		fits    = (rem_sh >= trial);
		rem_sub = rem_sh - trial;
	end

	// The valid flag is control and is cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= stage_in.valid;
		end
	end

	// Partial remainder, partial root and the rest of the radicand move on.
	always_ff @(posedge clk) begin
		tag_q  <= stage_in.tag;
		rem_q  <= fits ? rem_sub : rem_sh;
		root_q <= {stage_in.root[ROOT_W-2:0], fits};
		rad_q  <= {stage_in.rad[RAD_W-3:0], 2'b00};
	end

	always_comb begin
		stage_out.valid = valid_q;
		stage_out.tag   = tag_q;
		stage_out.rem   = rem_q;
		stage_out.root  = root_q;
		stage_out.rad   = rad_q;
	end

endmodule

// File: hdl/rsn_sqrt_chain.sv
// Row of square-root cells: a new radicand may enter every cycle, and its floor root
// leaves the last cell with its side data. Depends on rsn_pkg, rsn_sqrt_cell.
module rsn_sqrt_chain (
	input  logic               clk,
	input  logic               arst_n,
	input  rsn_pkg::sq_stage_t chain_in,
	output rsn_pkg::sq_stage_t chain_out
);
	import rsn_pkg::*;

	sq_stage_t stages [0:SQRT_CELLS];
	sq_stage_t first_stage;

	// A fresh job starts with an empty remainder and root.
	always_comb begin
		first_stage      = chain_in;
		first_stage.rem  = '0;
		first_stage.root = '0;
	end

	assign stages[0] = first_stage;

	// Each cell hands its job to the next one every cycle.
	for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_cell
		rsn_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.stage_in (stages[i]),
			.stage_out(stages[i+1])
		);
	end

	assign chain_out = stages[SQRT_CELLS];

endmodule

// File: hdl/rsn_div.sv
// Shade divider: color = (255*(len +/- mag) + len) / (2*len), one quotient bit a cycle.
// Depends on rsn_pkg only through the house import.
module rsn_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [29:0] mag,
	input  logic        neg,
	input  logic [30:0] len,
	output logic        done,
	output logic [7:0]  quo
);
	import rsn_pkg::*;

	logic [30:0] mag_c;
	logic [31:0] num;
	logic [40:0] dividend;
	logic [40:0] dsh_ext;

	logic        run_q;
	logic        done_q;
	logic [2:0]  cnt_q;
	logic [40:0] rem_q;
	logic [38:0] dsh_q;
	logic [7:0]  quo_q;

	// Clamp the magnitude to the length and form the dividend.
	always_comb begin
		mag_c    = ({1'b0, mag} > len) ? len : {1'b0, mag};
		num      = neg ? ({1'b0, len} - {1'b0, mag_c}) : ({1'b0, len} + {1'b0, mag_c});
		dividend = ({1'b0, num, 8'b0} - {9'b0, num}) + {10'b0, len};
		dsh_ext  = {2'b0, dsh_q};
	end

	// Step control: eight quotient bits after the start cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring division against a divisor that shifts right each step.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= {len, 8'b0};
			quo_q <= '0;
		end else if (run_q) begin
			if (rem_q >= dsh_ext) begin
				rem_q <= rem_q - dsh_ext;
				quo_q <= {quo_q[6:0], 1'b1};
			end else begin
				quo_q <= {quo_q[6:0], 1'b0};
			end
			dsh_q <= {1'b0, dsh_q[38:1]};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// File: hdl/ray_sphere_nearest_hit_shader_unit.sv
// Top level of the ray/sphere nearest-hit shader: command port, sphere table, sequencer.
// Depends on rsn_pkg, rsn_sqrt_chain (with rsn_sqrt_cell) and rsn_div.
//
// A load command (command 0) writes one sphere table entry and gives no result; busy
// stays low. A trace command (command 1) raises busy until its single result is shown
// for one cycle with done high; the receiver cannot hold it off. In a trace over N
// spheres one shared 35x32 multiplier forms each sphere's discriminant in turn, those
// discriminants stream through a 32-cell square-root chain, and the nearest hit then
// costs the multiplies for its normal and that normal's squared length, normalizing
// shifts as needed, one more pass through the chain and three divisions.
// With no sphere counted the result comes in the cycle after the command.
module ray_sphere_nearest_hit_shader_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            command,
	input  logic [rsn_pkg::SLOT_W-1:0]      sphere_slot,
	input  logic signed [31:0]              center_x,
	input  logic signed [31:0]              center_y,
	input  logic signed [31:0]              center_z,
	input  logic [30:0]                     sphere_radius,
	input  logic signed [15:0]              dir_x,
	input  logic signed [15:0]              dir_y,
	input  logic signed [15:0]              dir_z,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rsn_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_data,
	output logic                            done,
	output logic                            hit,
	output logic [30:0]                     distance,
	output logic [7:0]                      red,
	output logic [7:0]                      green,
	output logic [7:0]                      blue
);
	import rsn_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPH,
		ST_NRM,
		ST_SHF,
		ST_LSQ,
		ST_LWAIT,
		ST_DIV,
		ST_OUT
	} state_t;

	localparam logic [3:0] STEP_OC   = 4'd0;
	localparam logic [3:0] STEP_PUSH = 4'd10;
	localparam logic [3:0] NRM_LAST  = 4'd3;
	localparam logic [3:0] LSQ_PUSH  = 4'd4;

	// Configuration registers.
	logic signed [31:0]  origin_q [0:2];
	logic [COUNT_W-1:0]  sphere_count_q;

	// Sphere table.
	logic [2:0][31:0]    tbl_c_q [0:MAX_SPHERES-1];
	logic [30:0]         tbl_r_q [0:MAX_SPHERES-1];

	// Control.
	state_t              state_q;
	logic [3:0]          step_q;
	logic [COUNT_W-1:0]  n_q;
	logic [COUNT_W-1:0]  k_q;
	logic [COUNT_W-1:0]  collected_q;
	logic                found_q;
	logic                bk_v_s1;
	logic [1:0]          ch_q;
	logic                div_run_q;
	logic                done_q;
	logic                hit_q;
	logic [30:0]         distance_q;
	logic [7:0]          red_q;
	logic [7:0]          green_q;
	logic [7:0]          blue_q;

	// Datapath.
	logic signed [15:0]  dir_q [0:2];
	logic [2:0][31:0]    oc_q;
	logic [30:0]         r_q;
	logic signed [51:0]  sum_q;
	logic [31:0]         b_q;
	logic [63:0]         oc2_q;
	logic [63:0]         br_q;
	logic signed [66:0]  prod_q;
	logic signed [34:0]  bt_q;
	logic [2:0][31:0]    boc_q;
	logic signed [34:0]  t_s1;
	logic                tok_s1;
	logic [2:0][31:0]    oc_s1;
	logic [39:0]         mag_q [0:2];
	logic                neg_q [0:2];
	logic [30:0]         len_q;
	logic [7:0]          color_q [0:2];

	// Combinational.
	logic                accept;
	logic                issuing;
	logic [COUNT_W-1:0]  n_eff;
	logic signed [34:0]  mul_a;
	logic signed [31:0]  mul_b;
	logic signed [32:0]  oc_diff [0:2];
	logic signed [51:0]  sum_rnd;
	logic signed [34:0]  b_ext;
	logic signed [34:0]  sq_ext;
	logic signed [34:0]  t0;
	logic signed [34:0]  t1;
	logic                better_hit;
	logic signed [51:0]  dt_prod;
	logic signed [51:0]  dt_rnd;
	logic signed [39:0]  v_new;
	logic [1:0]          v_idx;
	logic                too_big;
	sq_stage_t           chain_in;
	sq_stage_t           chain_out;
	logic                div_start;
	logic                div_done;
	logic [7:0]          div_quo;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign issuing   = (k_q < n_q);
	assign n_eff     = (sphere_count_q > COUNT_W'(MAX_SPHERES)) ?
		COUNT_W'(MAX_SPHERES) : sphere_count_q;

	// Configuration writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q[0]    <= '0;
			origin_q[1]    <= '0;
			origin_q[2]    <= '0;
			sphere_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			priority case (cfg_index)
				REG_ORIGIN_X:     origin_q[0]    <= cfg_data;
				REG_ORIGIN_Y:     origin_q[1]    <= cfg_data;
				REG_ORIGIN_Z:     origin_q[2]    <= cfg_data;
				REG_SPHERE_COUNT: sphere_count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Load command writes one table entry.
	always_ff @(posedge clk) begin
		if (accept && (command == CMD_LOAD)) begin
			tbl_c_q[sphere_slot] <= {center_z, center_y, center_x};
			tbl_r_q[sphere_slot] <= sphere_radius;
		end
	end

	// Offsets from the sphere center to the origin, before saturation.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			oc_diff[i] = $signed({origin_q[i][31], origin_q[i]}) -
				$signed({tbl_c_q[k_q[SLOT_W-1:0]][i][31], tbl_c_q[k_q[SLOT_W-1:0]][i]});
		end
	end

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SPH: begin
				if (issuing) begin
					unique case (step_q)
						4'd1: begin
							mul_a = 35'($signed(oc_q[0]));
							mul_b = 32'(dir_q[0]);
						end
						4'd2: begin
							mul_a = 35'($signed(oc_q[1]));
							mul_b = 32'(dir_q[1]);
						end
						4'd3: begin
							mul_a = 35'($signed(oc_q[2]));
							mul_b = 32'(dir_q[2]);
						end
						4'd4: begin
							mul_a = 35'($signed(oc_q[0]));
							mul_b = $signed(oc_q[0]);
						end
						4'd5: begin
							mul_a = 35'($signed(oc_q[1]));
							mul_b = $signed(oc_q[1]);
						end
						4'd6: begin
							mul_a = 35'($signed(oc_q[2]));
							mul_b = $signed(oc_q[2]);
						end
						4'd7: begin
							mul_a = $signed({4'b0, r_q});
							mul_b = $signed({1'b0, r_q});
						end
						4'd8: begin
							mul_a = 35'($signed(b_q));
							mul_b = $signed(b_q);
						end
						default: ;
					endcase
				end
			end
			ST_NRM: begin
				mul_a = bt_q;
				unique case (step_q)
					4'd0:    mul_b = 32'(dir_q[0]);
					4'd1:    mul_b = 32'(dir_q[1]);
					4'd2:    mul_b = 32'(dir_q[2]);
					default: mul_b = '0;
				endcase
			end
			ST_LSQ: begin
				if (step_q < 4'd3) begin
					mul_a = $signed({5'b0, mag_q[step_q[1:0]][29:0]});
					mul_b = $signed({2'b0, mag_q[step_q[1:0]][29:0]});
				end
			end
			default: ;
		endcase
	end

	// Root selection for a sphere leaving the square-root chain.
	always_comb begin
		b_ext   = 35'($signed(chain_out.tag.b));
		sq_ext  = $signed({3'b0, chain_out.root});
		t0      = -b_ext - sq_ext;
		t1      = -b_ext + sq_ext;
		sum_rnd = (sum_q + 52'sd8192) >>> 14;
	end

	assign better_hit = bk_v_s1 && tok_s1 && (!found_q || (t_s1 < bt_q));

	// Normal component: offset plus direction times distance, rounded.
	always_comb begin
		dt_prod = prod_q[51:0];
		dt_rnd  = (dt_prod + 52'sd8192) >>> 14;
		v_idx   = step_q[1:0] - 2'd1;
		v_new   = 40'($signed(boc_q[v_idx])) + dt_rnd[39:0];
		too_big = (|mag_q[0][39:30]) || (|mag_q[1][39:30]) || (|mag_q[2][39:30]);
	end

	// Jobs for the square-root chain.
	always_comb begin
		chain_in           = '0;
		chain_in.tag.b     = b_q;
		chain_in.tag.oc    = oc_q;
		chain_in.tag.ok    = (br_q >= oc2_q);
		if (state_q == ST_SPH) begin
			chain_in.valid    = issuing && (step_q == STEP_PUSH);
			chain_in.tag.kind = KIND_SPHERE;
			chain_in.rad      = br_q - oc2_q;
		end else begin
			chain_in.valid    = (state_q == ST_LSQ) && (step_q == LSQ_PUSH);
			chain_in.tag.kind = KIND_NORMAL;
			chain_in.rad      = oc2_q;
		end
	end

	rsn_sqrt_chain u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.chain_in (chain_in),
		.chain_out(chain_out)
	);

	assign div_start = (state_q == ST_DIV) && !div_run_q;

	rsn_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.mag   (mag_q[ch_q][29:0]),
		.neg   (neg_q[ch_q]),
		.len   (len_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	// Sequencer and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			n_q         <= '0;
			k_q         <= '0;
			collected_q <= '0;
			found_q     <= 1'b0;
			bk_v_s1     <= 1'b0;
			ch_q        <= '0;
			div_run_q   <= 1'b0;
			done_q      <= 1'b0;
			hit_q       <= 1'b0;
			distance_q  <= '0;
			red_q       <= '0;
			green_q     <= '0;
			blue_q      <= '0;
		end else begin
			done_q  <= 1'b0;
			bk_v_s1 <= chain_out.valid && (chain_out.tag.kind == KIND_SPHERE);
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (command == CMD_TRACE)) begin
						n_q         <= n_eff;
						k_q         <= '0;
						collected_q <= '0;
						found_q     <= 1'b0;
						step_q      <= STEP_OC;
						if (n_eff == '0) begin
							done_q     <= 1'b1;
							hit_q      <= 1'b0;
							distance_q <= '0;
							red_q      <= BG_RED;
							green_q    <= BG_GREEN;
							blue_q     <= BG_BLUE;
						end else begin
							state_q <= ST_SPH;
						end
					end
				end
				ST_SPH: begin
					if (issuing) begin
						if (step_q == STEP_PUSH) begin
							step_q <= STEP_OC;
							k_q    <= k_q + COUNT_W'(1);
						end else begin
							step_q <= step_q + 4'd1;
						end
					end
					if (bk_v_s1) begin
						collected_q <= collected_q + COUNT_W'(1);
					end
					if (better_hit) begin
						found_q <= 1'b1;
					end
					if (collected_q == n_q) begin
						step_q <= '0;
						if (found_q) begin
							state_q <= ST_NRM;
						end else begin
							state_q    <= ST_IDLE;
							done_q     <= 1'b1;
							hit_q      <= 1'b0;
							distance_q <= '0;
							red_q      <= BG_RED;
							green_q    <= BG_GREEN;
							blue_q     <= BG_BLUE;
						end
					end
				end
				ST_NRM: begin
					if (step_q == NRM_LAST) begin
						state_q <= ST_SHF;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_SHF: begin
					if (!too_big) begin
						state_q <= ST_LSQ;
						step_q  <= '0;
					end
				end
				ST_LSQ: begin
					if (step_q == LSQ_PUSH) begin
						state_q <= ST_LWAIT;
						step_q  <= '0;
					end else begin
						step_q <= step_q + 4'd1;
					end
				end
				ST_LWAIT: begin
					if (chain_out.valid && (chain_out.tag.kind == KIND_NORMAL)) begin
						if (chain_out.root == '0) begin
							state_q    <= ST_IDLE;
							done_q     <= 1'b1;
							hit_q      <= 1'b1;
							distance_q <= (|bt_q[34:31]) ? 31'h7FFF_FFFF : bt_q[30:0];
							red_q      <= MID_GRAY;
							green_q    <= MID_GRAY;
							blue_q     <= MID_GRAY;
						end else begin
							state_q   <= ST_DIV;
							ch_q      <= '0;
							div_run_q <= 1'b0;
						end
					end
				end
				ST_DIV: begin
					if (!div_run_q) begin
						div_run_q <= 1'b1;
					end else if (div_done) begin
						div_run_q <= 1'b0;
						if (ch_q == 2'd2) begin
							state_q <= ST_OUT;
						end else begin
							ch_q <= ch_q + 2'd1;
						end
					end
				end
				ST_OUT: begin
					state_q    <= ST_IDLE;
					done_q     <= 1'b1;
					hit_q      <= 1'b1;
					distance_q <= (|bt_q[34:31]) ? 31'h7FFF_FFFF : bt_q[30:0];
					red_q      <= color_q[0];
					green_q    <= color_q[1];
					blue_q     <= color_q[2];
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Arithmetic registers, steered by the sequencer.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;

		// Back-end stage one: chosen root of the sphere leaving the chain.
		oc_s1  <= chain_out.tag.oc;
		tok_s1 <= chain_out.tag.ok && ((t0 > EPS_Q) || (t1 > EPS_Q));
		t_s1   <= (t0 > EPS_Q) ? t0 : t1;

		unique case (state_q)
			ST_IDLE: begin
				if (accept && (command == CMD_TRACE)) begin
					dir_q[0] <= dir_x;
					dir_q[1] <= dir_y;
					dir_q[2] <= dir_z;
				end
			end
			ST_SPH: begin
				if (issuing) begin
					unique case (step_q)
						4'd0: begin
							for (int i = 0; i < 3; i++) begin
								oc_q[i] <= sat32(40'(oc_diff[i]));
							end
							r_q <= tbl_r_q[k_q[SLOT_W-1:0]];
						end
						4'd2: sum_q <= prod_q[51:0];
						4'd3, 4'd4: sum_q <= sum_q + prod_q[51:0];
						4'd5: begin
							b_q   <= sat32(sum_rnd[39:0]);
							oc2_q <= prod_q[63:0];
						end
						4'd6, 4'd7: oc2_q <= oc2_q + prod_q[63:0];
						4'd8: br_q <= prod_q[63:0];
						4'd9: br_q <= br_q + prod_q[63:0];
						default: ;
					endcase
				end
				// Back-end stage two: keep the nearest hit, earlier entry on a tie.
				if (better_hit) begin
					bt_q  <= t_s1;
					boc_q <= oc_s1;
				end
			end
			ST_NRM: begin
				if (step_q != 4'd0) begin
					neg_q[v_idx] <= v_new[39];
					mag_q[v_idx] <= v_new[39] ? 40'(-v_new) : v_new;
				end
			end
			ST_SHF: begin
				if (too_big) begin
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= {1'b0, mag_q[i][39:1]};
					end
				end
			end
			ST_LSQ: begin
				unique case (step_q)
					4'd1: oc2_q <= prod_q[63:0];
					4'd2, 4'd3: oc2_q <= oc2_q + prod_q[63:0];
					default: ;
				endcase
			end
			ST_LWAIT: begin
				len_q <= chain_out.root[30:0];
			end
			ST_DIV: begin
				if (div_run_q && div_done) begin
					color_q[ch_q] <= div_quo;
				end
			end
			ST_OUT: ;
			default: ;
		endcase
	end

	assign done     = done_q;
	assign hit      = hit_q;
	assign distance = distance_q;
	assign red      = red_q;
	assign green    = green_q;
	assign blue     = blue_q;

endmodule
